>>> src/hcrt_pkg.sv
package hcrt_pkg;

  localparam logic [15:0] DEFAULT_ADDR  = 16'hFFFF;
  localparam logic [7:0]  UNREACHABLE   = 8'hFF;
  localparam logic [7:0]  DEFAULT_LIFE  = 8'd120;
  localparam logic [7:0]  RESET_REFRESH = 8'd100;

  typedef enum logic {
    ACT_ADVERTISE = 1'b0,
    ACT_TICK      = 1'b1
  } action_e;

  // queued command: distance already incremented and saturated
  typedef struct packed {
    action_e     action;
    logic [15:0] addr;
    logic [7:0]  distance;
  } cmd_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  distance;
    logic [7:0]  life;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        accepted;
    logic [15:0] parent_address;
    logic [7:0]  parent_distance;
    logic        advertise;
  } res_t;

endpackage

>>> src/hop_count_route_table_unit.sv
// Neighbor route table for hop-count distance-vector routing.
//
// Command channel: an item (action_i, src_address_i, hop_distance_i) is
// taken on a rising edge with start high and busy low. A two-deep command
// queue sits between the front end and the table engine, so busy only rises
// when two items wait behind the one in work.
// Result channel: result_valid_o pulses for one cycle per item with
// accepted_o, parent_address_o, parent_distance_o, entry_count_o and
// advertise_o. There is no back-pressure; the receiver must take each beat.
// Config channel: cfg_valid_i/cfg_ready_o/cfg_data_i writes refresh_life;
// ready is always high. Write it only while no item is in flight.
// Engine steps: a tick is one pass that ages, compacts and picks the parent
// (a memory read and a write a cycle); an advertisement for the default
// address goes straight to the write step, any other address first does a
// linear search (one read a cycle) before the write step. Items run one
// at a time in the engine; a queued item waits for the one ahead.
// Reset: table holds only the default route, refresh_life is 100. No
// clearing pass is needed; entries past the fill count are never read.
module hop_count_route_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int IS_SINK     = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [15:0] src_address_i,
  input  logic [7:0]  hop_distance_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic        accepted_o,
  output logic [15:0] parent_address_o,
  output logic [7:0]  parent_distance_o,
  output logic [3:0]  entry_count_o,
  output logic        advertise_o
);
  import hcrt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  logic           q_valid, q_ready, full;
  cmd_t           q_cmd;
  res_t           res;
  logic [IW-1:0]  used;
  logic [IW+3:0]  used_ext;
  logic [7:0]     refresh_life_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  // refresh lifetime register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_life_q <= RESET_REFRESH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      refresh_life_q <= cfg_data_i;
    end
  end

  hcrt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (start && !full),
    .action_i       (action_i),
    .src_address_i  (src_address_i),
    .hop_distance_i (hop_distance_i),
    .full_o         (full),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_cmd_o        (q_cmd)
  );

  hcrt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IS_SINK     (IS_SINK),
    .IW          (IW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_cmd_i        (q_cmd),
    .refresh_life_i (refresh_life_q),
    .res_o          (res),
    .used_o         (used)
  );

  // entry count is the low four bits of the fill count
  assign used_ext          = {4'b0000, used};
  assign entry_count_o     = used_ext[3:0];
  assign result_valid_o    = res.valid;
  assign accepted_o        = res.accepted;
  assign parent_address_o  = res.parent_address;
  assign parent_distance_o = res.parent_distance;
  assign advertise_o       = res.advertise;

endmodule

>>> src/hcrt_front.sv
module hcrt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               action_i,
  input  logic [15:0]        src_address_i,
  input  logic [7:0]         hop_distance_i,
  output logic               full_o,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output hcrt_pkg::cmd_t     q_cmd_o
);
  import hcrt_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       pop;

  always_comb begin
    cmd_in.action   = action_e'(action_i);
    cmd_in.addr     = src_address_i;
    cmd_in.distance = (hop_distance_i < UNREACHABLE) ? hop_distance_i + 8'd1 : UNREACHABLE;
  end

  assign full_o    = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = slot_q[rptr_q];
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

endmodule

>>> src/hcrt_back.sv
module hcrt_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int IS_SINK     = 0,
  parameter int IW          = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  hcrt_pkg::cmd_t     q_cmd_i,
  input  logic [7:0]         refresh_life_i,
  output hcrt_pkg::res_t     res_o,
  output logic [IW-1:0]      used_o
);
  import hcrt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_ADV_SCAN  = 4'b0010,
    ST_ADV_WRITE = 4'b0100,
    ST_TICK_SCAN = 4'b1000
  } state_e;

  localparam logic [IW-1:0] FULL     = IW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] ONE      = IW'(1);
  localparam logic [7:0]    D0_RESET = (IS_SINK != 0) ? 8'd0 : UNREACHABLE;

  // entries 1 and up; the default route lives in registers
  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [IW-1:0] used_q, used_d;
  logic [IW-1:0] par_idx_q, par_idx_d;
  logic [15:0]   par_addr_q, par_addr_d;
  logic [7:0]    par_dist_q, par_dist_d;
  logic [7:0]    d0_q, d0_d;
  logic [IW-1:0] rd_q, rd_d;
  logic [IW-1:0] wr_q, wr_d;
  logic          rvalid_q, rvalid_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [IW-1:0] pos_q, pos_d;
  logic          hit_q, hit_d;
  logic [7:0]    least_q, least_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [15:0]   best_addr_q, best_addr_d;
  logic [7:0]    best_dist_q, best_dist_d;
  res_t          res_q, res_d;

  logic          ren, we;
  logic [IW-1:0] raddr, waddr;
  entry_t        wdata;
  logic          match, keep;

  assign q_ready_o = (state_q == ST_IDLE);
  assign res_o     = res_q;
  assign used_o    = used_q;
  assign match     = rvalid_q && (rdata_q.addr == cmd_q.addr);
  assign keep      = rdata_q.life > 8'd1;   // survives aging

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    used_d      = used_q;
    par_idx_d   = par_idx_q;
    par_addr_d  = par_addr_q;
    par_dist_d  = par_dist_q;
    d0_d        = d0_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    least_d     = least_q;
    best_idx_d  = best_idx_q;
    best_addr_d = best_addr_q;
    best_dist_d = best_dist_q;
    res_d       = res_q;
    res_d.valid = 1'b0;
    ren         = 1'b0;
    raddr       = rd_q;
    we          = 1'b0;
    waddr       = wr_q;
    wdata       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          cmd_d = q_cmd_i;
          rd_d  = ONE;
          if (q_cmd_i.action == ACT_TICK) begin
            wr_d        = ONE;
            least_d     = d0_q;
            best_idx_d  = '0;
            best_addr_d = DEFAULT_ADDR;
            best_dist_d = d0_q;
            state_d     = ST_TICK_SCAN;
          end else if (q_cmd_i.addr == DEFAULT_ADDR) begin
            pos_d   = '0;
            hit_d   = 1'b1;
            state_d = ST_ADV_WRITE;
          end else begin
            state_d = ST_ADV_SCAN;
          end
        end
      end

      ST_ADV_SCAN: begin
        if (match) begin
          pos_d   = ridx_q;
          hit_d   = 1'b1;
          state_d = ST_ADV_WRITE;
        end else if (rd_q < used_q) begin
          ren      = 1'b1;
          rd_d     = rd_q + ONE;
          rvalid_d = 1'b1;
          ridx_d   = rd_q;
        end else begin
          // miss: append unless full
          pos_d   = used_q;
          hit_d   = (used_q != FULL);
          state_d = ST_ADV_WRITE;
        end
      end

      ST_ADV_WRITE: begin
        if (hit_q) begin
          if (pos_q != '0) begin
            we    = 1'b1;
            waddr = pos_q;
            wdata = '{addr: cmd_q.addr, distance: cmd_q.distance, life: refresh_life_i};
          end else begin
            d0_d = cmd_q.distance;
          end
          if (pos_q == used_q) begin
            used_d = used_q + ONE;
          end
          if (pos_q == par_idx_q) begin
            par_dist_d = cmd_q.distance;
          end
        end
        res_d.valid           = 1'b1;
        res_d.accepted        = hit_q;
        res_d.parent_address  = par_addr_q;
        res_d.parent_distance = par_dist_d;
        res_d.advertise       = 1'b0;
        state_d               = ST_IDLE;
      end

      ST_TICK_SCAN: begin
        // age, compact in place and track the minimum in one pass
        if (rvalid_q && keep) begin
          we    = 1'b1;
          waddr = wr_q;
          wdata = '{addr: rdata_q.addr, distance: rdata_q.distance,
                    life: rdata_q.life - 8'd1};
          wr_d  = wr_q + ONE;
          if (rdata_q.distance < least_q) begin
            least_d     = rdata_q.distance;
            best_idx_d  = wr_q;
            best_addr_d = rdata_q.addr;
            best_dist_d = rdata_q.distance;
          end
        end
        if (rd_q < used_q) begin
          ren      = 1'b1;
          rd_d     = rd_q + ONE;
          rvalid_d = 1'b1;
        end else if (!rvalid_q) begin
          used_d                = wr_q;
          par_idx_d             = best_idx_q;
          par_addr_d            = best_addr_q;
          par_dist_d            = best_dist_q;
          res_d.valid           = 1'b1;
          res_d.accepted        = 1'b1;
          res_d.parent_address  = best_addr_q;
          res_d.parent_distance = best_dist_q;
          res_d.advertise       = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= ONE;
      par_idx_q  <= '0;
      par_addr_q <= DEFAULT_ADDR;
      par_dist_q <= D0_RESET;
      d0_q       <= D0_RESET;
      rvalid_q   <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      par_idx_q  <= par_idx_d;
      par_addr_q <= par_addr_d;
      par_dist_q <= par_dist_d;
      d0_q       <= d0_d;
      rvalid_q   <= rvalid_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    rd_q        <= rd_d;
    wr_q        <= wr_d;
    ridx_q      <= ridx_d;
    pos_q       <= pos_d;
    hit_q       <= hit_d;
    least_q     <= least_d;
    best_idx_q  <= best_idx_d;
    best_addr_q <= best_addr_d;
    best_dist_q <= best_dist_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

>>> src/hcrt_checker.sv
module hcrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic        accepted_o,
  input logic        advertise_o
);

  // a tick beat is always accepted
  a_tick_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && advertise_o) |-> accepted_o)
    else $error("tick result not accepted");

  // the engine returns to idle after each result, so strobes never abut
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // the queue only fills up because of an accepted beat
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted beat");

endmodule

bind hop_count_route_table_unit hcrt_checker u_hcrt_checker (.*);

>>> tb/sv/hcrt_route_checker.sv
`timescale 1ns / 1ps

module hcrt_route_checker #(
  parameter int TABLE_DEPTH = 16,
  parameter int IS_SINK     = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_start_i,
  input  logic        cmd_busy_i,
  input  logic        cmd_action_i,
  input  logic [15:0] cmd_address_i,
  input  logic [7:0]  cmd_hop_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        res_valid_i,
  input  logic        res_accepted_i,
  input  logic [15:0] res_parent_address_i,
  input  logic [7:0]  res_parent_distance_i,
  input  logic [3:0]  res_entry_count_i,
  input  logic        res_advertise_i,
  output int          pending_o,
  output int          fail_count_o
);
  import hcrt_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [15:0] parent_address;
    logic [7:0]  parent_distance;
    logic [3:0]  entry_count;
    logic        advertise;
  } route_beat_t;

  entry_t      route_tbl [TABLE_DEPTH];
  int unsigned used_entries;
  int unsigned parent_slot;
  logic [7:0]  refresh_life;
  route_beat_t expected_beats [$];
  int          beat_num = 0;
  int          mismatch_total = 0;

  assign fail_count_o = mismatch_total;

  // print cap keeps a broken run readable; every mismatch is still counted
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_total++;
    if (mismatch_total <= 100)
      $display("mismatch at beat %0d, %s: got %0h want %0h", beat_num, what, got, want);
  endtask

  function automatic void reset_routes();
    for (int k = 0; k < TABLE_DEPTH; k++) route_tbl[k] = '0;
    route_tbl[0].addr     = DEFAULT_ADDR;
    route_tbl[0].distance = (IS_SINK != 0) ? 8'd0 : UNREACHABLE;
    route_tbl[0].life     = DEFAULT_LIFE;
    used_entries = 1;
    parent_slot  = 0;
    refresh_life = RESET_REFRESH;
  endfunction

  function automatic route_beat_t route_step(input action_e act, input logic [15:0] addr,
                                             input logic [7:0] hop);
    route_beat_t beat;
    logic [7:0]  new_dist;
    logic        hit;
    int unsigned pos;
    int unsigned wr;
    logic [7:0]  least;
    beat.accepted = 1'b1;
    if (act == ACT_ADVERTISE) begin
      new_dist = (hop < UNREACHABLE) ? hop + 8'd1 : UNREACHABLE;
      hit  = 1'b0;
      pos  = 0;
      for (int k = 0; k < used_entries; k++) begin
        if (!hit && route_tbl[k].addr == addr) begin
          hit = 1'b1;
          pos = k;
        end
      end
      if (!hit) begin
        if (used_entries >= TABLE_DEPTH - 1) begin
          beat.accepted = 1'b0;
        end else begin
          pos = used_entries;
          used_entries++;
          route_tbl[pos].addr = addr;
        end
      end
      if (beat.accepted) begin
        route_tbl[pos].distance = new_dist;
        route_tbl[pos].life     = refresh_life;
      end
    end else begin
      // age, drop expired, close gaps in order; entry 0 is never touched
      for (int k = 1; k < used_entries; k++)
        if (route_tbl[k].life != 8'd0) route_tbl[k].life--;
      wr = 1;
      for (int k = 1; k < used_entries; k++) begin
        if (route_tbl[k].life != 8'd0) begin
          route_tbl[wr] = route_tbl[k];
          wr++;
        end
      end
      for (int k = wr; k < used_entries; k++) route_tbl[k] = '0;
      used_entries = wr;
      least       = UNREACHABLE;
      parent_slot = 0;
      for (int k = 0; k < used_entries; k++) begin
        if (route_tbl[k].distance < least) begin
          least       = route_tbl[k].distance;
          parent_slot = k;
        end
      end
    end
    beat.parent_address  = route_tbl[parent_slot].addr;
    beat.parent_distance = route_tbl[parent_slot].distance;
    beat.entry_count     = used_entries[3:0];
    beat.advertise       = (act == ACT_TICK);
    return beat;
  endfunction

  task automatic check_beat();
    route_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected", 0, 0);
    end else begin
      want = expected_beats.pop_front();
      if (res_accepted_i !== want.accepted)
        report_mismatch("accepted", 32'(res_accepted_i), 32'(want.accepted));
      if (res_parent_address_i !== want.parent_address)
        report_mismatch("parent_address", 32'(res_parent_address_i),
                        32'(want.parent_address));
      if (res_parent_distance_i !== want.parent_distance)
        report_mismatch("parent_distance", 32'(res_parent_distance_i),
                        32'(want.parent_distance));
      if (res_entry_count_i !== want.entry_count)
        report_mismatch("entry_count", 32'(res_entry_count_i), 32'(want.entry_count));
      if (res_advertise_i !== want.advertise)
        report_mismatch("advertise", 32'(res_advertise_i), 32'(want.advertise));
    end
    beat_num++;
  endtask

  // results first: an item taken on this edge cannot have its beat out yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_routes();
      expected_beats.delete();
    end else begin
      if (res_valid_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) refresh_life = cfg_data_i;
      if (cmd_start_i && !cmd_busy_i)
        expected_beats.push_back(route_step(action_e'(cmd_action_i), cmd_address_i,
                                            cmd_hop_i));
    end
    pending_o = expected_beats.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hcrt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int IS_SINK     = 0;
  localparam int POOL_SIZE   = 24;
  // Slowest correct run: ~960 beats, each through the engine, plus sender
  // gaps (79% idle at most); the limit leaves a wide margin over that.
  localparam int LIMIT_CYCLES = 500000;
  // drain margin at the end, for a full-table tick or miss
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic        action_i          = 1'b0;
  logic [15:0] src_address_i     = '0;
  logic [7:0]  hop_distance_i    = '0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i        = '0;
  logic        result_valid_o;
  logic        accepted_o;
  logic [15:0] parent_address_o;
  logic [7:0]  parent_distance_o;
  logic [3:0]  entry_count_o;
  logic        advertise_o;

  int          pending;
  int          fail_count;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  logic [15:0] addr_pool [POOL_SIZE];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  hop_count_route_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IS_SINK    (IS_SINK)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .src_address_i    (src_address_i),
    .hop_distance_i   (hop_distance_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .accepted_o       (accepted_o),
    .parent_address_o (parent_address_o),
    .parent_distance_o(parent_distance_o),
    .entry_count_o    (entry_count_o),
    .advertise_o      (advertise_o)
  );

  // Checker sits beside the block, watching the same wires: it predicts the
  // beat of each accepted command and compares it with the result strobe.
  hcrt_route_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IS_SINK    (IS_SINK)
  ) route_chk (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_start_i          (start),
    .cmd_busy_i           (busy),
    .cmd_action_i         (action_i),
    .cmd_address_i        (src_address_i),
    .cmd_hop_i            (hop_distance_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_i          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .res_valid_i          (result_valid_o),
    .res_accepted_i       (accepted_o),
    .res_parent_address_i (parent_address_o),
    .res_parent_distance_i(parent_distance_o),
    .res_entry_count_i    (entry_count_o),
    .res_advertise_i      (advertise_o),
    .pending_o            (pending),
    .fail_count_o         (fail_count)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One command beat. Idle cycles (start low) come first, drawn per cycle,
  // so gaps land on every stage of the engine. start is never dropped after
  // an accept unless an idle cycle follows, so it is not lowered and raised
  // in one step. busy is read right after the edge, i.e. its value at the
  // edge, which is what the handshake uses.
  task automatic send_cmd(input action_e act, input logic [15:0] addr,
                          input logic [7:0] hop);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= act;
    src_address_i  <= addr;
    hop_distance_i <= hop;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected beat has come back.
  task automatic drain_beats();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // refresh_life is only written with the engine idle: every command gives
  // exactly one beat, so an empty expectation queue means nothing in flight.
  task automatic write_refresh_life(input logic [7:0] life);
    drain_beats();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= life;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random phase. Most advertisements come from a small neighbor pool so
  // entries get refreshed, the table fills to its limit and ticks age and
  // compact real entries; the rest are the default address and arbitrary
  // addresses (mostly misses, and rejects once the table is full).
  task automatic run_phase(input int beats, input logic [7:0] life, input int idle_pct,
                           input int tick_pct);
    action_e     act;
    logic [15:0] addr;
    logic [7:0]  hop;
    int          pick;
    write_refresh_life(life);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < beats; i++) begin
      act  = ($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_ADVERTISE;
      pick = $urandom_range(99);
      if (pick < 70)      addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 80) addr = DEFAULT_ADDR;
      else                addr = 16'($urandom_range(16'hFFFF));
      pick = $urandom_range(99);
      if (pick < 10)      hop = 8'd0;
      else if (pick < 20) hop = UNREACHABLE;
      else if (pick < 25) hop = UNREACHABLE - 8'd1;
      else                hop = 8'($urandom_range(8'hFF));
      send_cmd(act, addr, hop);
    end
  endtask

  initial begin
    // neighbor pool: odd slots differ from their neighbor in one byte only,
    // so a match on half the address would alias them
    for (int i = 0; i < POOL_SIZE; i += 2) begin
      addr_pool[i]     = 16'($urandom_range(16'hFFFF));
      addr_pool[i + 1] = addr_pool[i] ^ (i[1] ? 16'h0100 : 16'h0001);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, refresh_life at its reset value ---
    send_cmd(ACT_TICK, 16'h0000, 8'h00);        // tick with only the default route
    send_cmd(ACT_ADVERTISE, DEFAULT_ADDR, 8'h00); // default address refreshes entry 0
    send_cmd(ACT_ADVERTISE, 16'h0000, UNREACHABLE); // saturates at 255
    send_cmd(ACT_ADVERTISE, 16'h1234, 8'hFE);     // 254+1 reaches 255
    send_cmd(ACT_ADVERTISE, 16'h1334, 8'h03);     // high byte differs from 0x1234
    send_cmd(ACT_ADVERTISE, 16'h1235, 8'h03);     // low byte differs; ties on distance
    send_cmd(ACT_ADVERTISE, DEFAULT_ADDR, UNREACHABLE);
    send_cmd(ACT_TICK, 16'hFFFF, 8'hFF);          // first of the tied entries wins
    send_cmd(ACT_ADVERTISE, 16'h1234, 8'h00);     // better route, parent held till tick
    for (int i = 0; i < 10; i++)                  // fill up to TABLE_DEPTH-1 entries
      send_cmd(ACT_ADVERTISE, 16'(16'hA500 + i), 8'(i * 25));
    send_cmd(ACT_ADVERTISE, 16'h5A5A, 8'h01);     // full table: rejected
    send_cmd(ACT_ADVERTISE, 16'h1235, 8'h07);     // full table, known address: taken
    send_cmd(ACT_TICK, 16'h0000, 8'h00);

    write_refresh_life(8'd0);                     // lifetime already zero on next tick
    send_cmd(ACT_ADVERTISE, 16'h1334, 8'h02);
    send_cmd(ACT_TICK, 16'h0000, 8'h00);          // removes it, compacts the rest
    write_refresh_life(8'd1);
    send_cmd(ACT_ADVERTISE, 16'hC3C3, 8'h00);
    send_cmd(ACT_TICK, 16'h0000, 8'h00);

    // --- random part: settings from extreme to extreme, idling varied ---
    run_phase(155, 8'd255, 0, 12);                // long life: table stays full
    run_phase(155, 8'd1, 79, 30);                 // everything expires on each tick
    run_phase(155, 8'd3, 17, 20);
    run_phase(155, 8'($urandom_range(2, 12)), 0, 15);
    run_phase(155, 8'd40, 79, 8);
    run_phase(155, 8'($urandom_range(1, 255)), 17, 15);

    drain_beats();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
